// ----- src/multi_pattern_exact_match_defines.svh -----
// ----------------------------------------------------------------------------
// Pattern matcher assertion macros
// Clocked implication checks shared by the checker of the pattern matcher.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_EXACT_MATCH_DEFINES_SVH
`define MULTI_PATTERN_EXACT_MATCH_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MPEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MPEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mpem_pkg.sv -----
// ----------------------------------------------------------------------------
// Pattern matcher package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mpem_pkg;

  localparam int NUM_PATTERNS    = 16;
  localparam int MAX_PATTERN_LEN = 32;
  localparam int POSITION_WIDTH  = 32;

  localparam int SLOT_W    = 4;
  localparam int OFF_W     = 5;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int OUT_POS_W = 32;
  localparam int CNT_W     = $clog2(NUM_PATTERNS + 1);
  localparam int WIN_IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int MSEL_W    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load_wr;
    logic              text_acc;
    logic              rd_en;
    logic [MSEL_W-1:0] rd_slot;
    logic              cmp_en;
    logic [MSEL_W-1:0] cmp_slot;
    logic              emit;
    logic              finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hits_empty;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/mpem_in_if.sv -----
// ----------------------------------------------------------------------------
// Pattern matcher input channel
// Valid/ready channel carrying load and text items.
// ----------------------------------------------------------------------------
interface mpem_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [mpem_pkg::SLOT_W-1:0] pattern_slot;
  logic [mpem_pkg::OFF_W-1:0]  char_offset;
  logic [mpem_pkg::LEN_W-1:0]  pattern_len;
  logic [mpem_pkg::BYTE_W-1:0] byte_value;
  logic                      end_of_text;

  modport source (output valid, mode, pattern_slot, char_offset, pattern_len,
                  byte_value, end_of_text, input ready);
  modport sink (input valid, mode, pattern_slot, char_offset, pattern_len,
                byte_value, end_of_text, output ready);
endinterface

// ----------------------------------------------------------------------------
// Pattern matcher result channel
// Valid/ready channel carrying match reports.
// ----------------------------------------------------------------------------
interface mpem_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpem_pkg::SLOT_W-1:0]    match_slot;
  logic [mpem_pkg::OUT_POS_W-1:0] start_offset;
  logic                         last_match;

  modport source (output valid, match_slot, start_offset, last_match, input ready);
  modport sink (input valid, match_slot, start_offset, last_match, output ready);
endinterface

// ----- src/mpem_ctrl.sv -----
// ----------------------------------------------------------------------------
// Pattern matcher controller
// Sequences the slot scan and the report phase for each text item.
// ----------------------------------------------------------------------------
module mpem_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_mode,
  output logic                   in_ready,
  input  mpem_pkg::dp_status_t   status,
  output mpem_pkg::ctrl_cmd_t    cmd
);

  mpem_pkg::state_t state_r, state_nxt;
  logic [mpem_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic scan_done;

  assign scan_done = (cnt_r == mpem_pkg::CNT_W'(mpem_pkg::NUM_PATTERNS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpem_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      mpem_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && (in_mode == mpem_pkg::MODE_TEXT)) state_nxt = mpem_pkg::ST_SCAN;
      end
      mpem_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (scan_done) state_nxt = mpem_pkg::ST_EMIT;
      end
      mpem_pkg::ST_EMIT: begin
        if (status.hits_empty) state_nxt = mpem_pkg::ST_IDLE;
      end
      default: state_nxt = mpem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      mpem_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_wr  = in_valid && (in_mode == mpem_pkg::MODE_LOAD);
        cmd.text_acc = in_valid && (in_mode == mpem_pkg::MODE_TEXT);
      end
      mpem_pkg::ST_SCAN: begin
        cmd.rd_en    = !scan_done;
        cmd.rd_slot  = cnt_r[mpem_pkg::MSEL_W-1:0];
        cmd.cmp_en   = (cnt_r != '0);
        cmd.cmp_slot = mpem_pkg::MSEL_W'(cnt_r - 1'b1);
      end
      mpem_pkg::ST_EMIT: begin
        cmd.emit   = !status.hits_empty && status.out_free;
        cmd.finish = status.hits_empty;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/mpem_dp.sv -----
// ----------------------------------------------------------------------------
// Pattern matcher datapath
// Pattern memory, lengths, text window, comparator and result register.
// ----------------------------------------------------------------------------
module mpem_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mpem_pkg::ctrl_cmd_t               cmd,
  output mpem_pkg::dp_status_t              status,
  input  logic [mpem_pkg::SLOT_W-1:0]       in_slot,
  input  logic [mpem_pkg::OFF_W-1:0]        in_off,
  input  logic [mpem_pkg::LEN_W-1:0]        in_len,
  input  logic [mpem_pkg::BYTE_W-1:0]       in_byte,
  input  logic                              in_eot,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [mpem_pkg::SLOT_W-1:0]       out_slot,
  output logic [mpem_pkg::OUT_POS_W-1:0]    out_start,
  output logic                              out_last
);

  localparam int ROW_W = mpem_pkg::MAX_PATTERN_LEN * mpem_pkg::BYTE_W;
  localparam int NP    = mpem_pkg::NUM_PATTERNS;
  localparam int ML    = mpem_pkg::MAX_PATTERN_LEN;
  localparam int PW    = mpem_pkg::POSITION_WIDTH;

  // One row per pattern, written one byte lane at a time.
  logic [ROW_W-1:0] mem [NP];
  logic [ROW_W-1:0] row_r;

  logic [mpem_pkg::LEN_W-1:0]  len_r [NP];
  logic [mpem_pkg::BYTE_W-1:0] win_r [ML];
  logic [mpem_pkg::LEN_W-1:0]  fill_r;
  logic [PW-1:0]               pos_r, cur_pos_r;
  logic                        eot_r;
  logic [NP-1:0]               hits_r;
  logic                        out_valid_r;
  logic [mpem_pkg::SLOT_W-1:0]    out_slot_r;
  logic [mpem_pkg::OUT_POS_W-1:0] out_start_r;
  logic                        out_last_r;

  logic                        slot_ok, off_ok;
  logic [mpem_pkg::LEN_W-1:0]  wr_len;
  logic [mpem_pkg::LEN_W-1:0]  cmp_len;
  logic                        hit;
  logic [mpem_pkg::MSEL_W-1:0] sel;
  logic [NP-1:0]               sel_mask;
  logic [PW-1:0]               start_full;

  assign slot_ok = int'(in_slot) < NP;
  assign off_ok  = int'(in_off) < ML;
  assign wr_len  = (int'(in_len) > ML) ? mpem_pkg::LEN_W'(ML) : in_len;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok && off_ok)
      mem[mpem_pkg::MSEL_W'(in_slot)][in_off*mpem_pkg::BYTE_W +: mpem_pkg::BYTE_W] <= in_byte;
    if (cmd.rd_en) row_r <= mem[cmd.rd_slot];
  end

  // Compare the pattern row with the window: pattern byte i meets the text
  // byte that lies len-1-i places back from the newest one.
  assign cmp_len = len_r[cmd.cmp_slot];
  always_comb begin
    logic [mpem_pkg::LEN_W-1:0] back;
    hit = (cmp_len != '0) && (cmp_len <= fill_r);
    for (int i = 0; i < ML; i++) begin
      back = cmp_len - mpem_pkg::LEN_W'(i) - 1'b1;
      if ((mpem_pkg::LEN_W'(i) < cmp_len) &&
          (row_r[i*mpem_pkg::BYTE_W +: mpem_pkg::BYTE_W] !=
           win_r[back[mpem_pkg::WIN_IDX_W-1:0]]))
        hit = 1'b0;
    end
  end

  // Lowest pending slot is reported first.
  always_comb begin
    sel = '0;
    for (int s = NP - 1; s >= 0; s--)
      if (hits_r[s]) sel = mpem_pkg::MSEL_W'(s);
  end
  assign sel_mask   = NP'(1) << sel;
  assign start_full = cur_pos_r - PW'(len_r[sel]) + PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NP; s++) len_r[s] <= '0;
      for (int k = 0; k < ML; k++) win_r[k] <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
      eot_r       <= 1'b0;
    end else begin
      if (cmd.load_wr && slot_ok) len_r[mpem_pkg::MSEL_W'(in_slot)] <= wr_len;
      if (cmd.text_acc) begin
        win_r[0] <= in_byte;
        for (int k = 1; k < ML; k++) win_r[k] <= win_r[k-1];
        if (int'(fill_r) < ML) fill_r <= fill_r + 1'b1;
        cur_pos_r <= pos_r;
        pos_r     <= pos_r + 1'b1;
        eot_r     <= in_eot;
        hits_r    <= '0;
      end
      if (cmd.cmp_en && hit) hits_r[cmd.cmp_slot] <= 1'b1;
      if (cmd.emit) begin
        hits_r      <= hits_r & ~sel_mask;
        out_valid_r <= 1'b1;
        out_slot_r  <= mpem_pkg::SLOT_W'(sel);
        out_start_r <= mpem_pkg::OUT_POS_W'(start_full);
        out_last_r  <= ((hits_r & ~sel_mask) == '0);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish && eot_r) begin
        for (int k = 0; k < ML; k++) win_r[k] <= '0;
        fill_r <= '0;
        pos_r  <= '0;
        eot_r  <= 1'b0;
      end
    end
  end

  assign status.hits_empty = (hits_r == '0);
  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_start = out_start_r;
  assign out_last  = out_last_r;

endmodule

// ----- src/multi_pattern_exact_match.sv -----
// ----------------------------------------------------------------------------
// Multi-pattern exact matcher
// Reports every stored pattern that ends on each incoming text byte.
// ----------------------------------------------------------------------------
// Load items (mode 0) write one pattern byte and that pattern's length and
// leave the block ready for the next item. A text item (mode 1) shifts its
// byte into the window and then scans the pattern slots one per cycle
// through the registered read port of the pattern memory. After the scan
// every matching slot is reported in rising slot order, one result per cycle
// while the sink takes them, the last one flagged, and a final step in the
// report state closes the item. Only then is the input ready again, so a
// stalling result sink keeps the block busy. The start offset is the text
// position of the first matching byte, counted from reset or from the last
// end of text. The end-of-text flag clears position and window once that
// byte's results are out. The pattern memory needs no clearing after reset;
// lengths reset to zero so that every pattern starts disabled.
module multi_pattern_exact_match (
  input  logic        clk,
  input  logic        rst_n,
  mpem_in_if.sink     in_ch,
  mpem_out_if.source  out_ch
);

  mpem_pkg::ctrl_cmd_t  cmd;
  mpem_pkg::dp_status_t status;

  // Sequencer for scan and report phases.
  mpem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, comparison and the result register.
  mpem_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_slot   (in_ch.pattern_slot),
    .in_off    (in_ch.char_offset),
    .in_len    (in_ch.pattern_len),
    .in_byte   (in_ch.byte_value),
    .in_eot    (in_ch.end_of_text),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_slot  (out_ch.match_slot),
    .out_start (out_ch.start_offset),
    .out_last  (out_ch.last_match)
  );

endmodule

// ----- src/mpem_checker.sv -----
// ----------------------------------------------------------------------------
// Pattern matcher checker
// Port-level assertions on the matcher, bound to its top level.
// ----------------------------------------------------------------------------
`include "multi_pattern_exact_match_defines.svh"

module mpem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  logic take_load;
  logic take_text;

  assign take_load = in_valid && in_ready && (in_mode == mpem_pkg::MODE_LOAD);
  assign take_text = in_valid && in_ready && (in_mode == mpem_pkg::MODE_TEXT);

  // A load item never makes the block busy.
  `MPEM_ASSERT_NEXT(a_load_keeps_ready, take_load, in_ready, "load item stalled input")
  // A text item always starts a scan.
  `MPEM_ASSERT_NEXT(a_text_busy, take_text, !in_ready, "text item did not start scan")
  // More results for the current byte are pending, so no new item is taken.
  `MPEM_ASSERT_NOW(a_no_accept_mid_report, out_valid && !out_last, !in_ready, "early ready")
  // A stalled result stays offered.
  `MPEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule

bind multi_pattern_exact_match mpem_checker u_mpem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_match)
);

// ----- verif/multi_pattern_exact_match_tb.sv -----
// ----------------------------------------------------------------------------
// Multi-pattern exact matcher testbench
// Loads patterns and streams text through the valid/ready channels, predicts
// every match report in a scoreboard and compares each one field by field.
// ----------------------------------------------------------------------------
module multi_pattern_exact_match_tb;

  // Bus form of one input item and one match report.
  typedef struct packed {
    logic                        mode;
    logic [mpem_pkg::SLOT_W-1:0] slot;
    logic [mpem_pkg::OFF_W-1:0]  offset;
    logic [mpem_pkg::LEN_W-1:0]  len;
    logic [mpem_pkg::BYTE_W-1:0] value;
    logic                        eot;
  } scan_item_t;

  typedef struct packed {
    logic [mpem_pkg::SLOT_W-1:0]    slot;
    logic [mpem_pkg::OUT_POS_W-1:0] start;
    logic                           last;
  } match_t;

  // A text item with no match still keeps the block busy for a full scan of
  // the slots, so this many cycles follow the last expected report.
  localparam int SETTLE_CYCLES = mpem_pkg::NUM_PATTERNS + 8;
  localparam int NP = mpem_pkg::NUM_PATTERNS;
  localparam int ML = mpem_pkg::MAX_PATTERN_LEN;

  logic clk;
  logic rst_n;

  mpem_in_if  in_if ();
  mpem_out_if out_if ();

  multi_pattern_exact_match u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the matcher state.
  logic [mpem_pkg::BYTE_W-1:0] pat_bytes [NP][ML];
  int unsigned                 pat_len   [NP];
  logic [mpem_pkg::BYTE_W-1:0] recent    [ML];
  int unsigned                 fill_count;
  logic [mpem_pkg::POSITION_WIDTH-1:0] text_pos;

  // Which pattern bytes have been written; a slot is never given a length
  // that would cover an unwritten byte.
  bit written [NP][ML];

  match_t pending_matches[$];
  int     error_count;

  // Flow control knobs: idle_enabled is shared by the sender and the receiver.
  bit idle_enabled;
  int hold_off_cycles;

  // Updates the shadow state for one accepted item and queues the reports
  // that it should cause.
  task automatic predict_matches(input scan_item_t it);
    int unsigned l;
    bit          hit;
    match_t      m;
    int          found;
    found = 0;
    if (it.mode == mpem_pkg::MODE_LOAD) begin
      l = (it.len > ML) ? ML : it.len;
      pat_len[it.slot] = l;
      pat_bytes[it.slot][it.offset] = it.value;
    end else begin
      for (int k = ML - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = it.value;
      if (fill_count < ML) fill_count++;
      for (int s = 0; s < NP; s++) begin
        l = pat_len[s];
        if (l == 0 || l > fill_count) continue;
        hit = 1'b1;
        for (int i = 0; i < l; i++)
          if (pat_bytes[s][i] != recent[l-1-i]) hit = 1'b0;
        if (!hit) continue;
        m.slot  = s[mpem_pkg::SLOT_W-1:0];
        m.start = mpem_pkg::OUT_POS_W'(text_pos - mpem_pkg::POSITION_WIDTH'(l - 1));
        m.last  = 1'b0;
        pending_matches = {pending_matches, m};
        found++;
      end
      if (found > 0) pending_matches[pending_matches.size()-1].last = 1'b1;
      text_pos = text_pos + 1'b1;
      if (it.eot) begin
        foreach (recent[k]) recent[k] = '0;
        fill_count = 0;
        text_pos   = '0;
      end
    end
  endtask

  // Offers one item, optionally after a random idle burst, and waits until
  // the block takes it. Valid stays high afterwards so that back-to-back
  // items need no second assignment in the same step.
  task automatic send_item(input scan_item_t it);
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.pattern_slot <= it.slot;
    in_if.char_offset  <= it.offset;
    in_if.pattern_len  <= it.len;
    in_if.byte_value   <= it.value;
    in_if.end_of_text  <= it.eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_matches(it);
  endtask

  // Count of contiguous written bytes from the start of a pattern.
  function automatic int unsigned written_prefix(input int slot);
    int unsigned p;
    p = 0;
    while (p < ML && written[slot][p]) p++;
    return p;
  endfunction

  // Writes one pattern byte with the given length. Ignored fields of a load
  // item get random values.
  task automatic load_byte(input int slot, input int off, input logic [7:0] value,
                           input int len);
    scan_item_t it;
    written[slot][off] = 1'b1;
    it.mode   = mpem_pkg::MODE_LOAD;
    it.slot   = slot[mpem_pkg::SLOT_W-1:0];
    it.offset = off[mpem_pkg::OFF_W-1:0];
    it.len    = len[mpem_pkg::LEN_W-1:0];
    it.value  = value;
    it.eot    = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Writes a whole pattern; the slot stays disabled until its last byte.
  // A full-length pattern sometimes gets an oversized length to saturate.
  task automatic load_pattern(input int slot, input logic [7:0] bytes[$]);
    int n;
    n = bytes.size();
    for (int i = 0; i < n; i++)
      load_byte(slot, i, bytes[i],
                (i < n - 1) ? 0 :
                (n == ML) ? int'($urandom_range(ML, 63)) : n);
  endtask

  task automatic send_text(input logic [7:0] value, input bit eot);
    scan_item_t it;
    it.mode   = mpem_pkg::MODE_TEXT;
    it.slot   = mpem_pkg::SLOT_W'($urandom_range(0, 15));
    it.offset = mpem_pkg::OFF_W'($urandom_range(0, 31));
    it.len    = mpem_pkg::LEN_W'($urandom_range(0, 63));
    it.value  = value;
    it.eot    = eot;
    send_item(it);
  endtask

  // Mostly a small alphabet so that random text hits the patterns often.
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'(8'h61 + $urandom_range(0, 2));
  endfunction

  // Stops offering items and waits until every expected report is out and
  // the block has finished any scan that produces none.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Overlapping matches, a pattern that needs more text than has arrived
  // since the end flag, and the extreme byte values.
  task automatic test_directed_basics();
    load_pattern(0, '{8'h61, 8'h62});
    load_pattern(1, '{8'h62});
    load_pattern(2, '{8'h62, 8'h61, 8'h62});
    load_pattern(3, '{8'hFF, 8'h00});
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h62, 1'b1);
    // After the end flag the window is clear, so only the single-byte
    // pattern may match here.
    send_text(8'h62, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);
    wait_drained();
  endtask

  // A full-length pattern, whose length may be oversized and saturate, first fed
  // a text one byte too short and then the complete pattern.
  task automatic test_long_pattern();
    logic [7:0] bytes[$];
    for (int i = 0; i < ML; i++) bytes = {bytes, 8'(i * 37 + 5)};
    load_pattern(15, bytes);
    for (int i = 1; i < ML; i++)
      send_text(bytes[i], i == ML - 1);
    for (int i = 0; i < ML; i++) send_text(bytes[i], 1'b0);
    send_text(bytes[0], 1'b1);
    wait_drained();
  endtask

  // Every slot matches the same byte, giving the most reports per item.
  task automatic test_all_slots_hit();
    for (int s = 0; s < NP; s++) load_pattern(s, '{8'h5A});
    send_text(8'h5A, 1'b0);
    send_text(8'h5A, 1'b1);
    wait_drained();
  endtask

  // Mostly well-formed pattern loads and text runs with random content,
  // plus stray load items that rewrite a byte and the slot's length.
  task automatic test_random_traffic(input int budget);
    int          sent;
    int          n;
    int          slot;
    int unsigned p;
    logic [7:0]  bytes[$];
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          slot = $urandom_range(0, NP - 1);
          n = ($urandom_range(0, 9) == 0) ? ML : $urandom_range(1, 4);
          bytes.delete();
          for (int i = 0; i < n; i++) bytes = {bytes, text_byte()};
          load_pattern(slot, bytes);
          sent += n;
        end
        2: begin
          slot = $urandom_range(0, NP - 1);
          n = $urandom_range(0, ML - 1);
          written[slot][n] = 1'b1;
          p = written_prefix(slot);
          load_byte(slot, n, 8'($urandom_range(0, 255)),
                    (p == ML && $urandom_range(0, 1)) ?
                    int'($urandom_range(ML, 63)) : int'($urandom_range(0, p)));
          sent++;
        end
        default: begin
          n = $urandom_range(3, 20);
          for (int i = 0; i < n; i++)
            send_text(text_byte(), i == n - 1 && $urandom_range(0, 2) == 0);
          sent += n;
        end
      endcase
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while matching text keeps
  // coming, so the block fills up and must stall its input.
  task automatic test_receiver_hold();
    load_pattern(0, '{8'h61});
    hold_off_cycles = 400;
    for (int i = 0; i < 30; i++) send_text(8'h61, 1'b0);
    wait_drained();
  endtask

  // Closing stretch with neither side idling.
  task automatic test_steady_stream();
    idle_enabled = 1'b0;
    for (int i = 0; i < 40; i++) send_text(text_byte(), i == 39);
    wait_drained();
  endtask

  // Receiver: random stall bursts, the long hold when asked, and steady
  // readiness once idling is switched off.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else if (!idle_enabled) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compares each accepted report with the oldest expectation.
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected report slot=%0d start=%0d last=%0b", $time,
                 out_if.match_slot, out_if.start_offset, out_if.last_match);
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (out_if.match_slot !== want.slot) begin
          $display("%0t: match_slot expected %0d actual %0d", $time, want.slot,
                   out_if.match_slot);
          error_count++;
        end
        if (out_if.start_offset !== want.start) begin
          $display("%0t: start_offset expected %0d actual %0d", $time, want.start,
                   out_if.start_offset);
          error_count++;
        end
        if (out_if.last_match !== want.last) begin
          $display("%0t: last_match expected %0b actual %0b", $time, want.last,
                   out_if.last_match);
          error_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    error_count     = 0;
    idle_enabled    = 1'b1;
    hold_off_cycles = 0;
    fill_count      = 0;
    text_pos        = '0;
    foreach (pat_len[s]) pat_len[s] = 0;
    foreach (recent[k]) recent[k] = '0;
    foreach (written[s, i]) written[s][i] = 1'b0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = mpem_pkg::MODE_LOAD;
    in_if.pattern_slot = '0;
    in_if.char_offset  = '0;
    in_if.pattern_len  = '0;
    in_if.byte_value   = '0;
    in_if.end_of_text  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_long_pattern();
    test_all_slots_hit();
    test_random_traffic(100);
    test_receiver_hold();
    test_steady_stream();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
